### hw/rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie-break.
// No dependencies; imported by every other file of the block.
package lfu_pkg;

    localparam int CAP_W  = 5;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } lfu_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } lfu_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } lfu_sts_t;

endpackage

### hw/rtl/lfu_if.sv
// Handshake channel interfaces: request, response and configuration write.
// Depends on lfu_pkg for field widths.
interface lfu_req_if;
    import lfu_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
    modport source (output valid, mode, key, value, input ready);
    modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lfu_rsp_if;
    import lfu_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    modport source (output valid, found, read_value, input ready);
    modport sink   (input valid, found, read_value, output ready);
endinterface

interface lfu_cfg_if;
    import lfu_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/lfu_cache_lru_tiebreak_unit.sv
// A request is answered once the entry scan has visited every entry and the commit has run.
// The single-lane entry scan holds off the next request until the current one commits.
// The response register lets the next request be taken while a response waits.
// Reset (rst_n, asynchronous, active low) empties the cache and sets capacity to 16.
// Depends on lfu_pkg, lfu_if, lfu_ctrl and lfu_datapath.
module lfu_cache_lru_tiebreak_unit #(
    parameter int ENTRIES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lfu_req_if.sink   req,
    lfu_rsp_if.source rsp,
    lfu_cfg_if.sink   cfg
);
    import lfu_pkg::*;

    // The controller walks accept, scan and commit; the datapath holds all
    // entry state and reports when the scan reaches the last entry and
    // whether the response register can take a new transfer.
    lfu_cmd_t cmd;
    lfu_sts_t sts;
    logic     req_ready;

    // Configuration writes are always taken; the user must send them only while idle, which the block does not enforce.
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lfu_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_mode       (req.mode),
        .req_key        (req.key),
        .req_value      (req.value),
        .cfg_valid      (cfg.valid),
        .cfg_data       (cfg.data),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_found      (rsp.found),
        .rsp_read_value (rsp.read_value)
    );

endmodule

### hw/rtl/lfu_ctrl.sv
// Sequencer of the LFU cache: accept, scan over all entries, commit.
// Depends on lfu_pkg for the state, command and status types.
module lfu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  lfu_pkg::lfu_sts_t sts,
    output lfu_pkg::lfu_cmd_t cmd
);
    import lfu_pkg::*;

    lfu_state_t state_reg;
    lfu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (req_valid) state_next = ST_SCAN;
            ST_SCAN:   if (sts.scan_last) state_next = ST_COMMIT;
            ST_COMMIT: if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_SCAN:   cmd.step   = 1'b1;
            ST_COMMIT: cmd.commit = sts.out_free;
            default:   req_ready  = 1'b0;
        endcase
    end

endmodule

### hw/rtl/lfu_datapath.sv
// Entry storage, scan trackers, parallel commit update and output register.
// Depends on lfu_pkg for widths, constants and command/status types.
module lfu_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lfu_pkg::lfu_cmd_t                cmd,
    output lfu_pkg::lfu_sts_t                sts,
    input  logic                             req_mode,
    input  logic signed [lfu_pkg::KEY_W-1:0] req_key,
    input  logic signed [lfu_pkg::VAL_W-1:0] req_value,
    input  logic                             cfg_valid,
    input  logic [lfu_pkg::CAP_W-1:0]        cfg_data,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output logic                             rsp_found,
    output logic signed [lfu_pkg::VAL_W-1:0] rsp_read_value
);
    import lfu_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (CAP_W > OW) ? CAP_W : OW;

    // Entry storage; each lane is also read in parallel during commit.
    logic             valid_reg [ENTRIES];
    logic [KEY_W-1:0] key_reg   [ENTRIES];
    logic [VAL_W-1:0] val_reg   [ENTRIES];
    logic [CNT_W-1:0] cnt_reg   [ENTRIES];
    logic [IW-1:0]    rank_reg  [ENTRIES];
    logic [OW-1:0]    occ_reg;
    logic [CAP_W-1:0] cap_reg;

    // Captured request.
    logic             mode_reg;
    logic [KEY_W-1:0] rkey_reg;
    logic [VAL_W-1:0] rval_reg;

    // Scan trackers.
    logic [IW-1:0]    idx_reg;
    logic             hit_reg;
    logic [IW-1:0]    hit_idx_reg;
    logic [IW-1:0]    hit_rank_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [VAL_W-1:0] hit_val_reg;
    logic             vic_reg;
    logic [IW-1:0]    vic_idx_reg;
    logic [IW-1:0]    vic_rank_reg;
    logic [CNT_W-1:0] vic_cnt_reg;
    logic             free_reg;
    logic [IW-1:0]    free_idx_reg;

    logic             out_valid_reg;
    logic             out_found_reg;
    logic [VAL_W-1:0] out_value_reg;

    // Lane under scan.
    logic             lane_valid;
    logic [KEY_W-1:0] lane_key;
    logic [CNT_W-1:0] lane_cnt;
    logic [IW-1:0]    lane_rank;
    logic             lane_better;

    assign lane_valid = valid_reg[idx_reg];
    assign lane_key   = key_reg[idx_reg];
    assign lane_cnt   = cnt_reg[idx_reg];
    assign lane_rank  = rank_reg[idx_reg];
    assign lane_better = !vic_reg || (lane_cnt < vic_cnt_reg) ||
                         ((lane_cnt == vic_cnt_reg) && (lane_rank > vic_rank_reg));

    assign sts.scan_last = (idx_reg == IW'(ENTRIES - 1));
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_valid)
            cap_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= req_mode;
            rkey_reg <= unsigned'(req_key);
            rval_reg <= unsigned'(req_value);
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            vic_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            idx_reg <= IW'(idx_reg + 1'b1);
            if (lane_valid)
            begin
                if (!hit_reg && lane_key == rkey_reg)
                begin
                    hit_reg      <= 1'b1;
                    hit_idx_reg  <= idx_reg;
                    hit_rank_reg <= lane_rank;
                    hit_cnt_reg  <= lane_cnt;
                    hit_val_reg  <= val_reg[idx_reg];
                end
                if (lane_better)
                begin
                    vic_reg      <= 1'b1;
                    vic_idx_reg  <= idx_reg;
                    vic_rank_reg <= lane_rank;
                    vic_cnt_reg  <= lane_cnt;
                end
            end
            else if (!free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= idx_reg;
            end
        end
    end

    // Commit decision.
    logic [CW-1:0] cap_ext;
    logic [CW-1:0] cap_eff;
    logic          cap_ok;
    logic          full;
    logic          upd;
    logic          do_fill;
    logic          new_slot;
    logic [IW-1:0] tgt;
    logic [IW:0]   thr;
    logic [CNT_W-1:0] tgt_cnt;

    always_comb
    begin
        cap_ext  = CW'(cap_reg);
        cap_eff  = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
        cap_ok   = (cap_eff != '0);
        full     = (CW'(occ_reg) >= cap_eff);
        upd      = 1'b0;
        do_fill  = 1'b0;
        new_slot = 1'b0;
        tgt      = hit_idx_reg;
        thr      = {1'b0, hit_rank_reg};
        tgt_cnt  = (hit_cnt_reg == CNT_MAX) ? hit_cnt_reg : hit_cnt_reg + 1'b1;
        if (hit_reg)
        begin
            upd = (mode_reg == MODE_GET) || cap_ok;
        end
        else if (mode_reg == MODE_PUT && cap_ok)
        begin
            if (full)
            begin
                // Evicting and refilling one slot only ages entries younger than it.
                upd     = vic_reg;
                do_fill = vic_reg;
                tgt     = vic_idx_reg;
                thr     = {1'b0, vic_rank_reg};
            end
            else
            begin
                upd      = free_reg;
                do_fill  = free_reg;
                new_slot = free_reg;
                tgt      = free_idx_reg;
                thr      = (IW + 1)'(ENTRIES);
            end
            tgt_cnt = CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ENTRIES; j++)
                valid_reg[j] <= 1'b0;
            occ_reg <= '0;
        end
        else if (cmd.commit && new_slot)
        begin
            valid_reg[tgt] <= 1'b1;
            occ_reg        <= OW'(occ_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && upd)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (IW'(j) == tgt)
                    rank_reg[j] <= '0;
                else if (valid_reg[j] && ({1'b0, rank_reg[j]} < thr))
                    rank_reg[j] <= IW'(rank_reg[j] + 1'b1);
            end
            cnt_reg[tgt] <= tgt_cnt;
            if (mode_reg == MODE_PUT)
                val_reg[tgt] <= rval_reg;
            if (do_fill)
                key_reg[tgt] <= rkey_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_found_reg <= hit_reg;
            out_value_reg <= (hit_reg && mode_reg == MODE_GET) ? hit_val_reg : '0;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_found      = out_found_reg;
    assign rsp_read_value = signed'(out_value_reg);

endmodule
